/* sv/aesru_pkg.sv */
// Shared types, constants, S-box tables and GF(2^8) helpers for the AES round unit.
package aesru_pkg;

    typedef enum logic [2:0] {
        FUNC_ENC      = 3'd0,
        FUNC_ENC_LAST = 3'd1,
        FUNC_DEC      = 3'd2,
        FUNC_DEC_LAST = 3'd3,
        FUNC_INV_MIX  = 3'd4,
        FUNC_KEYGEN   = 3'd5
    } func_t;

    localparam logic [7:0] AES_POLY = 8'h1b;

    typedef logic [7:0] byte_t;
    typedef byte_t [15:0] state_t;

    localparam logic [7:0] SBOX_FWD [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] SBOX_INV [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam logic [3:0] PERM_FWD [16] = '{
        4'd0,4'd5,4'd10,4'd15,4'd4,4'd9,4'd14,4'd3,4'd8,4'd13,4'd2,4'd7,4'd12,4'd1,4'd6,4'd11
    };
    localparam logic [3:0] PERM_INV [16] = '{
        4'd0,4'd13,4'd10,4'd7,4'd4,4'd1,4'd14,4'd11,4'd8,4'd5,4'd2,4'd15,4'd12,4'd9,4'd6,4'd3
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return a[7] ? ({a[6:0], 1'b0} ^ AES_POLY) : {a[6:0], 1'b0};
    endfunction

endpackage

/* sv/aesru_sub_lane.sv */
// One byte lane: row shift select and forward or inverse S-box lookup.
module aesru_sub_lane (
    input  aesru_pkg::state_t state_in,
    input  logic [3:0]        fwd_src,
    input  logic [3:0]        inv_src,
    input  logic              inverse,
    output logic [7:0]        sub_out
);
    import aesru_pkg::*;

    assign sub_out = inverse ? SBOX_INV[state_in[inv_src]] : SBOX_FWD[state_in[fwd_src]];
endmodule

/* sv/aesru_mix_lane.sv */
// One column lane: forward or inverse MixColumns on four bytes.
module aesru_mix_lane (
    input  logic [31:0] col_in,
    input  logic        inverse,
    output logic [31:0] col_out
);
    import aesru_pkg::*;

    byte_t b [4];
    byte_t x2 [4];
    byte_t x4 [4];
    byte_t x8 [4];
    byte_t m9 [4];
    byte_t mb [4];
    byte_t md [4];
    byte_t me [4];
    byte_t m3 [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            b[k]  = col_in[8*k +: 8];
            x2[k] = xtime(b[k]);
            x4[k] = xtime(x2[k]);
            x8[k] = xtime(x4[k]);
            m9[k] = x8[k] ^ b[k];
            mb[k] = x8[k] ^ x2[k] ^ b[k];
            md[k] = x8[k] ^ x4[k] ^ b[k];
            me[k] = x8[k] ^ x4[k] ^ x2[k];
            m3[k] = x2[k] ^ b[k];
        end
        for (int r = 0; r < 4; r++) begin
            if (inverse) begin
                col_out[8*r +: 8] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
            end else begin
                col_out[8*r +: 8] = x2[r] ^ m3[(r+1)%4] ^ b[(r+2)%4] ^ b[(r+3)%4];
            end
        end
    end
endmodule

/* sv/aes_round_unit_core.sv */
// Top level of the AES round unit: lanes, merge and output register.
//
// Usage: present func, state_lo, state_hi and round_const on the s_ channel
// with s_valid; the item transfers when s_valid and s_ready are high.
// Two stages: the first registers the sixteen S-box lanes (with the row
// shift ahead of them), the second runs four MixColumns lanes and merges
// the result per operation into the output register on the m_ channel.
// Throughput is one item per cycle while m_ready is high. Each stage
// advances whenever its successor is empty or being drained, so a stall
// on m_ready backs up through the stages and s_ready falls only when
// both hold data.
// Keygen assist looks up words 1 and 3 of the registered input state in
// forward S-boxes of its own in the second stage.
// Selectors 6 and 7 pass the state through unchanged.
// Reset (aresetn low, synchronous) empties both stages; data is not cleared.
module aes_round_unit_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [63:0] s_state_lo,
    input  logic [63:0] s_state_hi,
    input  logic [7:0]  s_round_const,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_lo,
    output logic [63:0] m_result_hi
);
    import aesru_pkg::*;

    state_t st_in;
    state_t sub_bytes;
    logic   inv_sel;

    logic        v1_reg;
    logic [2:0]  func1_reg;
    state_t      sub1_reg;
    state_t      raw1_reg;
    logic [7:0]  rc1_reg;

    logic        v2_reg;
    logic [127:0] res_reg;
    logic [127:0] res_next;

    logic adv1;
    logic adv2;

    logic [127:0] mix_in;
    logic [127:0] mix_out;
    logic [31:0]  w1;
    logic [31:0]  w3;

    assign st_in   = {s_state_hi, s_state_lo};
    assign inv_sel = (s_func == FUNC_DEC) || (s_func == FUNC_DEC_LAST);

    for (genvar i = 0; i < 16; i++) begin : g_sub
        aesru_sub_lane u_lane (
            .state_in (st_in),
            .fwd_src  (PERM_FWD[i]),
            .inv_src  (PERM_INV[i]),
            .inverse  (inv_sel),
            .sub_out  (sub_bytes[i])
        );
    end

    assign adv2    = !v2_reg || m_ready;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_valid;
            if (adv2) v2_reg <= v1_reg;
        end
        if (adv1 && s_valid) begin
            func1_reg <= s_func;
            sub1_reg  <= sub_bytes;
            raw1_reg  <= st_in;
            rc1_reg   <= s_round_const;
        end
        if (adv2 && v1_reg) res_reg <= res_next;
    end

    // Inverse MixColumns alone works on the input state, not the substituted bytes
    assign mix_in = (func1_reg == FUNC_INV_MIX) ? raw1_reg : sub1_reg;

    for (genvar c = 0; c < 4; c++) begin : g_mix
        aesru_mix_lane u_mix (
            .col_in  (mix_in[32*c +: 32]),
            .inverse (func1_reg != FUNC_ENC),
            .col_out (mix_out[32*c +: 32])
        );
    end

    always_comb begin
        w1 = '0;
        w3 = '0;
        for (int k = 0; k < 4; k++) begin
            w1[8*k +: 8] = SBOX_FWD[raw1_reg[4+k]];
            w3[8*k +: 8] = SBOX_FWD[raw1_reg[12+k]];
        end
        unique case (func1_reg)
            FUNC_ENC, FUNC_DEC, FUNC_INV_MIX: res_next = mix_out;
            FUNC_ENC_LAST, FUNC_DEC_LAST:     res_next = sub1_reg;
            FUNC_KEYGEN: res_next = {
                {w3[7:0], w3[31:8]} ^ {24'd0, rc1_reg}, w3,
                {w1[7:0], w1[31:8]} ^ {24'd0, rc1_reg}, w1};
            default: res_next = raw1_reg;
        endcase
    end

    assign m_valid     = v2_reg;
    assign m_result_lo = res_reg[63:0];
    assign m_result_hi = res_reg[127:64];
endmodule
